// ----- src/ubxsfx_pkg.sv -----
// Shared types and constants for the UBX navigation subframe extractor.
// No dependencies; the parser, emitter and top level refer to it by scoped names.
`default_nettype none

package ubxsfx_pkg;

    // Frame sync pattern
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // Configuration register reset values
    localparam logic [7:0] ACCEPT_CLASS_RST  = 8'h02;
    localparam logic [7:0] ACCEPT_ID_RST     = 8'h13;
    localparam logic [7:0] ACCEPT_CONST_RST  = 8'd5;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ACCEPT_CLASS = 2'd0,
        CFG_ACCEPT_ID    = 2'd1,
        CFG_ACCEPT_CONST = 2'd2
    } cfg_index_t;

    // Payload header layout and acceptance limits
    localparam logic [7:0] MIN_WORDS   = 8'd8;
    localparam logic [7:0] MAX_SIG_ID  = 8'd1;
    localparam logic [10:0] WORD_BASE  = 11'd8;
    localparam logic [5:0] NAV_ADDR_BASE = 6'd8;

    // Emission: 32 nav bytes, the last keeps only its two top bits (250 bits)
    localparam logic [4:0] NAV_LAST_K    = 5'd31;
    localparam logic [7:0] NAV_LAST_MASK = 8'hC0;

    // Byte parser phases
    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } phase_t;

    // Emission sequencer states
    typedef enum logic [1:0] {
        EM_IDLE = 2'd0,
        EM_READ = 2'd1,
        EM_LOAD = 2'd2
    } emit_state_t;

    // Parser to emitter: frame passed all checks
    typedef struct packed {
        logic       start;
        logic [7:0] sat_id;
    } frame_go_t;

endpackage

`default_nettype wire

// ----- src/ubxsfx_store.sv -----
// Payload byte store: one write port, one registered read port.
// Depends on nothing outside this file.
`default_nettype none

module ubxsfx_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data_reg
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/ubxsfx_parser.sv -----
// Byte-level UBX frame parser: sync hunt, header, checksum, acceptance checks.
// Holds the configuration registers; writes payload bytes to ubxsfx_store.
// Uses ubxsfx_pkg.
`default_nettype none

module ubxsfx_parser #(
    parameter int PAYLOAD_BYTES = 256,
    parameter int AW            = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // accepted input byte
    input  wire logic                  in_valid,
    input  wire logic [7:0]            in_byte,
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [7:0]            cfg_data,
    // payload store write port
    output logic                       mem_we,
    output logic [AW-1:0]              mem_waddr,
    output logic [7:0]                 mem_wdata,
    // frame accepted
    output ubxsfx_pkg::frame_go_t      go
);

    ubxsfx_pkg::phase_t phase_reg, phase_next;

    logic [7:0]  acc_class_reg, acc_id_reg, acc_const_reg;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    // payload header bytes kept aside so the checks need no store reads
    logic [7:0]  const_reg, const_next;
    logic [7:0]  sat_reg, sat_next;
    logic [7:0]  sig_reg, sig_next;
    logic [7:0]  words_reg, words_next;

    logic [15:0] new_len;
    logic [15:0] count_inc;
    logic [7:0]  add_a, add_b, start_a;
    logic [10:0] need_len;
    logic        len_ok, frame_ok;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_class_reg <= ubxsfx_pkg::ACCEPT_CLASS_RST;
            acc_id_reg    <= ubxsfx_pkg::ACCEPT_ID_RST;
            acc_const_reg <= ubxsfx_pkg::ACCEPT_CONST_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ubxsfx_pkg::CFG_ACCEPT_CLASS: acc_class_reg <= cfg_data;
                ubxsfx_pkg::CFG_ACCEPT_ID:    acc_id_reg    <= cfg_data;
                ubxsfx_pkg::CFG_ACCEPT_CONST: acc_const_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Shared datapath terms
    assign new_len   = {in_byte, len_reg[7:0]};
    assign count_inc = count_reg + 16'd1;
    assign start_a   = in_byte;                 // sums restart on the class byte
    assign add_a     = sum_a_reg + in_byte;
    assign add_b     = sum_b_reg + add_a;
    assign len_ok    = (new_len != 16'd0) &&
                       ({1'b0, new_len} <= 17'(PAYLOAD_BYTES));
    assign need_len  = ubxsfx_pkg::WORD_BASE + {1'b0, words_reg, 2'b00};
    assign frame_ok  = (in_byte == sum_b_reg) &&
                       (class_reg == acc_class_reg) && (id_reg == acc_id_reg) &&
                       (len_reg >= 16'(ubxsfx_pkg::WORD_BASE)) &&
                       (const_reg == acc_const_reg) &&
                       (sig_reg <= ubxsfx_pkg::MAX_SIG_ID) &&
                       (words_reg >= ubxsfx_pkg::MIN_WORDS) &&
                       (len_reg >= 16'(need_len));

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (in_valid) begin
            unique case (phase_reg)
                ubxsfx_pkg::PH_SYNC1:
                    if (in_byte == ubxsfx_pkg::SYNC_FIRST) phase_next = ubxsfx_pkg::PH_SYNC2;
                ubxsfx_pkg::PH_SYNC2:
                    phase_next = (in_byte == ubxsfx_pkg::SYNC_SECOND) ?
                                 ubxsfx_pkg::PH_CLASS : ubxsfx_pkg::PH_SYNC1;
                ubxsfx_pkg::PH_CLASS:  phase_next = ubxsfx_pkg::PH_ID;
                ubxsfx_pkg::PH_ID:     phase_next = ubxsfx_pkg::PH_LEN_LO;
                ubxsfx_pkg::PH_LEN_LO: phase_next = ubxsfx_pkg::PH_LEN_HI;
                ubxsfx_pkg::PH_LEN_HI:
                    phase_next = len_ok ? ubxsfx_pkg::PH_PAYLOAD : ubxsfx_pkg::PH_SYNC1;
                ubxsfx_pkg::PH_PAYLOAD:
                    if (count_inc >= len_reg) phase_next = ubxsfx_pkg::PH_CK_A;
                ubxsfx_pkg::PH_CK_A:
                    phase_next = (in_byte == sum_a_reg) ?
                                 ubxsfx_pkg::PH_CK_B : ubxsfx_pkg::PH_SYNC1;
                ubxsfx_pkg::PH_CK_B:   phase_next = ubxsfx_pkg::PH_SYNC1;
                default:               phase_next = ubxsfx_pkg::PH_SYNC1;
            endcase
        end
    end

    // Datapath updates, store writes and frame start
    always_comb begin
        class_next = class_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        count_next = count_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        const_next = const_reg;
        sat_next   = sat_reg;
        sig_next   = sig_reg;
        words_next = words_reg;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[AW-1:0];
        mem_wdata  = in_byte;
        go.start   = 1'b0;
        go.sat_id  = sat_reg;
        if (in_valid) begin
            unique case (phase_reg)
                ubxsfx_pkg::PH_CLASS: begin
                    class_next = in_byte;
                    sum_a_next = start_a;
                    sum_b_next = start_a;
                end
                ubxsfx_pkg::PH_ID: begin
                    id_next    = in_byte;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                end
                ubxsfx_pkg::PH_LEN_LO: begin
                    len_next   = {8'd0, in_byte};
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                end
                ubxsfx_pkg::PH_LEN_HI: begin
                    len_next   = new_len;
                    count_next = 16'd0;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                end
                ubxsfx_pkg::PH_PAYLOAD: begin
                    // length was bounded by the store depth, so count stays in range
                    mem_we     = 1'b1;
                    count_next = count_inc;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    if (count_reg == 16'd0) const_next = in_byte;
                    if (count_reg == 16'd1) sat_next   = in_byte;
                    if (count_reg == 16'd2) sig_next   = in_byte;
                    if (count_reg == 16'd4) words_next = in_byte;
                end
                ubxsfx_pkg::PH_CK_A: begin
                    if (in_byte != sum_a_reg) begin
                        count_next = 16'd0;
                        sum_a_next = 8'd0;
                        sum_b_next = 8'd0;
                    end
                end
                ubxsfx_pkg::PH_CK_B: go.start = frame_ok;
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ubxsfx_pkg::PH_SYNC1;
            class_reg <= 8'd0;
            id_reg    <= 8'd0;
            len_reg   <= 16'd0;
            count_reg <= 16'd0;
            sum_a_reg <= 8'd0;
            sum_b_reg <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            class_reg <= class_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    // Header copies (payload only, always rewritten before use)
    always_ff @(posedge aclk) begin
        const_reg <= const_next;
        sat_reg   <= sat_next;
        sig_reg   <= sig_next;
        words_reg <= words_next;
    end

endmodule

`default_nettype wire

// ----- src/ubxsfx_emitter.sv -----
// Nav byte emission sequencer: reads 32 payload bytes from the store in
// word-swapped order and drives the output register. Uses ubxsfx_pkg.
`default_nettype none

module ubxsfx_emitter #(
    parameter int AW = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ubxsfx_pkg::frame_go_t go,
    output logic                       busy,
    // store read port
    output logic                       rd_en,
    output logic [AW-1:0]              rd_addr,
    input  wire logic [7:0]            rd_data,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 out_nav,
    output logic [4:0]                 out_index,
    output logic [7:0]                 out_sat,
    output logic                       out_last
);

    ubxsfx_pkg::emit_state_t state_reg, state_next;

    logic [4:0] k_reg, k_next;
    logic [7:0] sat_reg;
    logic       valid_reg, valid_next;
    logic [7:0] nav_reg;
    logic [4:0] index_reg;
    logic [7:0] osat_reg;
    logic       last_reg;
    logic       slot_free, load, is_last;

    assign slot_free = !valid_reg || out_ready;
    assign is_last   = (k_reg == ubxsfx_pkg::NAV_LAST_K);

    // Nav byte k comes from payload byte 8 + 4*(k/4) + 3 - k%4
    assign rd_addr = AW'(ubxsfx_pkg::NAV_ADDR_BASE + {1'b0, k_reg[4:2], ~k_reg[1:0]});

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ubxsfx_pkg::EM_IDLE: if (go.start) state_next = ubxsfx_pkg::EM_READ;
            ubxsfx_pkg::EM_READ: state_next = ubxsfx_pkg::EM_LOAD;
            ubxsfx_pkg::EM_LOAD:
                if (slot_free) state_next = is_last ? ubxsfx_pkg::EM_IDLE : ubxsfx_pkg::EM_READ;
            default: state_next = ubxsfx_pkg::EM_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        rd_en  = 1'b0;
        load   = 1'b0;
        busy   = 1'b1;
        k_next = k_reg;
        unique case (state_reg)
            ubxsfx_pkg::EM_IDLE: begin
                busy   = 1'b0;
                k_next = 5'd0;
            end
            ubxsfx_pkg::EM_READ: rd_en = 1'b1;
            ubxsfx_pkg::EM_LOAD: begin
                load = slot_free;
                if (slot_free) k_next = k_reg + 5'd1;
            end
            default: ;
        endcase
    end

    // Output valid flag: set on load, cleared on transfer
    always_comb begin
        valid_next = valid_reg;
        if (load) valid_next = 1'b1;
        else if (out_ready) valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ubxsfx_pkg::EM_IDLE;
            k_reg     <= 5'd0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (go.start && state_reg == ubxsfx_pkg::EM_IDLE) begin
            sat_reg <= go.sat_id;
        end
        if (load) begin
            nav_reg   <= is_last ? (rd_data & ubxsfx_pkg::NAV_LAST_MASK) : rd_data;
            index_reg <= k_reg;
            osat_reg  <= sat_reg;
            last_reg  <= is_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_nav   = nav_reg;
    assign out_index = index_reg;
    assign out_sat   = osat_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

// ----- src/ubx_sfrbx_frame_extractor_core.sv -----
// UBX navigation subframe extractor, top level.
// Instantiates ubxsfx_parser, ubxsfx_store and ubxsfx_emitter; uses ubxsfx_pkg.
//
// Usage:
//   s_ channel: one received serial byte per transfer (s_tdata[7:0]).
//   m_ channel: 32 nav bytes per accepted frame, in order, tlast on the 32nd.
//   cfg_we/cfg_index/cfg_data: write accept class (0), id (1), constellation (2);
//   write only while no frame is being emitted.
// Throughput and emission:
//   While parsing, one input byte is taken every cycle. The payload goes into
//   a single-port-write, registered-read store of PAYLOAD_BYTES entries.
//   On the second checksum byte of an accepted frame the emitter reads the
//   store once per nav byte, through a read state and then a load state;
//   a stalled receiver holds it in the load state. The first nav byte
//   reaches m_tvalid via the store read register and the output register.
//   s_tready is low during the burst, which also keeps store writes and
//   reads apart; the final nav byte may still wait while input resumes.
// Reset (aresetn low, synchronous): parser back to sync hunt, sums and
//   counters cleared, config registers to their defaults, output emptied.
//   The store itself is not cleared.
// Stall: the output register holds its byte until m_tready; the emitter
//   waits, and input stays blocked until the last byte is loaded.
`default_nettype none

module ubx_sfrbx_frame_extractor_core #(
    parameter int PAYLOAD_BYTES = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    // nav bytes
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] nav_byte, [12:8] byte_index,
                                        // [20:13] satellite_id, [23:21] zero
    output logic             m_tlast,   // last_of_frame
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int AW = $clog2(PAYLOAD_BYTES);

    ubxsfx_pkg::frame_go_t go;
    logic          in_valid, busy;
    logic          mem_we, rd_en;
    logic [AW-1:0] mem_waddr, rd_addr;
    logic [7:0]    mem_wdata, rd_data;
    logic [7:0]    out_nav, out_sat;
    logic [4:0]    out_index;

    assign s_tready = !busy;
    assign in_valid = s_tvalid && s_tready;

    ubxsfx_parser #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .AW            (AW)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_byte   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .go        (go)
    );

    ubxsfx_store #(
        .DEPTH (PAYLOAD_BYTES),
        .AW    (AW)
    ) u_store (
        .aclk        (aclk),
        .wr_en       (mem_we),
        .wr_addr     (mem_waddr),
        .wr_data     (mem_wdata),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data_reg (rd_data)
    );

    ubxsfx_emitter #(
        .AW (AW)
    ) u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .go        (go),
        .busy      (busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_nav   (out_nav),
        .out_index (out_index),
        .out_sat   (out_sat),
        .out_last  (m_tlast)
    );

    assign m_tdata = {3'd0, out_sat, out_index, out_nav};

endmodule

`default_nettype wire

// ----- src/ubxsfx_checker.sv -----
// Port-level checks for the UBX subframe extractor, bound to the top level.
// Sees only top-level ports; no package dependency.
`default_nettype none

module ubxsfx_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Last byte sits at index 31 with its six low bits cleared
    a_last_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[12:8] == 5'd31 && m_tdata[5:0] == 6'd0)
        else $error("malformed last nav byte");

    // Input stays blocked while a burst is still in progress
    a_burst_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken during burst");

    // After the end of a burst, any new result opens a fresh subframe
    a_burst_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tdata[12:8] == 5'd0)
        else $error("burst continued past its last byte");

endmodule

bind ubx_sfrbx_frame_extractor_core ubxsfx_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
